>>> rtl/ifsa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ifsa_pkg: shared types and constants of the IMU FIFO sample assembler
// Holds word widths, register indexes and the structs passed between modules.
// ----------------------------------------------------------------------------
package ifsa_pkg;

  localparam int WORD_W      = 16;
  localparam int TS_W        = 24;
  localparam int POS_W       = 4;
  localparam int GROUP_WORDS = 3;
  localparam int FULL_SET    = 9;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 1;

  // Register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_GYRO_EN  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ACCEL_EN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TIME_EN  = 2'd2;

  typedef struct packed {
    logic gyro_active;
    logic accel_enable;
    logic time_steps_enable;
  } ifsa_cfg_t;

  // Set position status handed from the capture stage to the top level
  typedef struct packed {
    logic             emit;     // current word closes a set
    logic [POS_W-1:0] set_len;  // words per set, zero when nothing enabled
    logic [POS_W-1:0] pos;      // index of the next word within the set
  } ifsa_ctrl_t;

  typedef struct packed {
    logic [WORD_W-1:0] gyro_x;
    logic [WORD_W-1:0] gyro_y;
    logic [WORD_W-1:0] gyro_z;
    logic [WORD_W-1:0] accel_x;
    logic [WORD_W-1:0] accel_y;
    logic [WORD_W-1:0] accel_z;
    logic [TS_W-1:0]   time_stamp;
    logic [WORD_W-1:0] step_total;
  } ifsa_sample_t;

endpackage

>>> rtl/ifsa_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ifsa_word_if / ifsa_sample_if: valid/ready channels of the assembler
// One channel carries raw FIFO words, the other assembled samples.
// ----------------------------------------------------------------------------
interface ifsa_word_if;
  logic        valid;
  logic        ready;
  logic [15:0] fifo_word;

  modport source (output valid, output fifo_word, input ready);
  modport sink   (input valid, input fifo_word, output ready);
endinterface

interface ifsa_sample_if;
  logic        valid;
  logic        ready;
  logic [15:0] gyro_x;
  logic [15:0] gyro_y;
  logic [15:0] gyro_z;
  logic [15:0] accel_x;
  logic [15:0] accel_y;
  logic [15:0] accel_z;
  logic [23:0] time_stamp;
  logic [15:0] step_total;

  modport source (output valid, output gyro_x, output gyro_y, output gyro_z,
                  output accel_x, output accel_y, output accel_z,
                  output time_stamp, output step_total, input ready);
  modport sink   (input valid, input gyro_x, input gyro_y, input gyro_z,
                  input accel_x, input accel_y, input accel_z,
                  input time_stamp, input step_total, output ready);
endinterface

>>> rtl/ifsa_capture.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ifsa_capture: set position counter and held word registers
// Counts words within a set and keeps every word of the set but the last.
// ----------------------------------------------------------------------------
module ifsa_capture import ifsa_pkg::*; #(
  parameter int MAX_SET_WORDS = 9
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ifsa_cfg_t         cfg_i,
  input  logic              realign_i,
  input  logic              accept_i,
  input  logic [WORD_W-1:0] word_i,
  output ifsa_ctrl_t        ctrl_o,
  output logic [WORD_W-1:0] held_o [0:MAX_SET_WORDS-2]
);

  logic [POS_W-1:0] pos_q, pos_d;
  logic [POS_W-1:0] grp_words;
  logic [POS_W-1:0] set_len;
  logic [POS_W-1:0] pos_inc;
  logic             last;

  always_comb begin
    grp_words = POS_W'(GROUP_WORDS) *
                (POS_W'(cfg_i.gyro_active) + POS_W'(cfg_i.accel_enable) +
                 POS_W'(cfg_i.time_steps_enable));
    set_len = (grp_words > POS_W'(MAX_SET_WORDS)) ? POS_W'(MAX_SET_WORDS) : grp_words;
  end

  assign pos_inc = pos_q + POS_W'(1);
  assign last    = (pos_inc >= set_len);

  always_comb begin
    pos_d = pos_q;
    if (realign_i) begin
      pos_d = '0;
    end else if (accept_i) begin
      pos_d = last ? '0 : pos_inc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else begin
      pos_q <= pos_d;
    end
  end

  // Hold each word of the set at its own slot
  for (genvar i = 0; i < MAX_SET_WORDS - 1; i++) begin : g_held
    logic [WORD_W-1:0] held_q;
    always_ff @(posedge clk_i) begin
      if (accept_i && !realign_i && !last && pos_q == POS_W'(i)) begin
        held_q <= word_i;
      end
    end
    assign held_o[i] = held_q;
  end

  assign ctrl_o.emit    = last;
  assign ctrl_o.set_len = set_len;
  assign ctrl_o.pos     = pos_q;

endmodule

>>> rtl/ifsa_format.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ifsa_format: sample field mapping
// Lines up held words and the closing word, then picks each group's words.
// ----------------------------------------------------------------------------
module ifsa_format import ifsa_pkg::*; #(
  parameter int MAX_SET_WORDS = 9
) (
  input  ifsa_cfg_t         cfg_i,
  input  logic [POS_W-1:0]  set_len_i,
  input  logic [WORD_W-1:0] word_i,
  input  logic [WORD_W-1:0] held_i [0:MAX_SET_WORDS-2],
  output ifsa_sample_t      sample_o
);

  logic [WORD_W-1:0] w [0:FULL_SET-1];
  logic [WORD_W-1:0] a0, a1, a2, t0, t1, t2;

  // Slot i: held word if before the closing word, closing word, else zero
  for (genvar i = 0; i < FULL_SET; i++) begin : g_slot
    logic [WORD_W-1:0] held_val;
    if (i < MAX_SET_WORDS - 1) begin : g_have
      assign held_val = held_i[i];
    end else begin : g_none
      assign held_val = '0;
    end
    always_comb begin
      if (set_len_i == POS_W'(i + 1)) begin
        w[i] = word_i;
      end else if (set_len_i > POS_W'(i + 1)) begin
        w[i] = held_val;
      end else begin
        w[i] = '0;
      end
    end
  end

  always_comb begin
    if (cfg_i.gyro_active) begin
      a0 = w[3]; a1 = w[4]; a2 = w[5];
    end else begin
      a0 = w[0]; a1 = w[1]; a2 = w[2];
    end
    unique case ({cfg_i.gyro_active, cfg_i.accel_enable})
      2'b11:   begin t0 = w[6]; t1 = w[7]; t2 = w[8]; end
      2'b10,
      2'b01:   begin t0 = w[3]; t1 = w[4]; t2 = w[5]; end
      default: begin t0 = w[0]; t1 = w[1]; t2 = w[2]; end
    endcase
  end

  always_comb begin
    sample_o = '0;
    if (cfg_i.gyro_active) begin
      sample_o.gyro_x = w[0];
      sample_o.gyro_y = w[1];
      sample_o.gyro_z = w[2];
    end
    if (cfg_i.accel_enable) begin
      sample_o.accel_x = a0;
      sample_o.accel_y = a1;
      sample_o.accel_z = a2;
    end
    if (cfg_i.time_steps_enable) begin
      // low byte of the second time word is dropped
      sample_o.time_stamp = {t0[15:8], t0[7:0], t1[15:8]};
      sample_o.step_total = t2;
    end
  end

endmodule

>>> rtl/imu_fifo_sample_assembler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imu_fifo_sample_assembler: rebuilds IMU samples from a FIFO word stream
// Counts words within a sample set and emits one sample per completed set.
// ----------------------------------------------------------------------------
// Usage:
//   word_i   : one 16-bit FIFO word per handshake. Each set holds three words
//              per enabled group: gyro x/y/z, then accel x/y/z, then two
//              timestamp words and the step count.
//   sample_o : one assembled sample per set; disabled groups read as zero.
//              With no group enabled, every word gives an all-zero sample.
//   cfg_*    : write port for gyro_active (0), accel_enable (1) and
//              time_steps_enable (2). Any write to one of these realigns the
//              block to the start of a set; other indexes are ignored.
//              Write only while no word is in flight.
// Throughput: one word per cycle while the receiver holds ready high. The single
//   output register shows a set's sample in the cycle after its closing word.
// Reset: enables clear and the set position returns to zero; held words
//   need no clearing, each is written before it is read.
// Stall: while a sample waits in the output register and the receiver holds
//   ready low, word_i.ready drops; when ready is high a new word enters in
//   the same cycle the waiting sample leaves.
// ----------------------------------------------------------------------------
module imu_fifo_sample_assembler import ifsa_pkg::*; #(
  parameter int MAX_SET_WORDS = 9
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  ifsa_word_if.sink             word_i,
  ifsa_sample_if.source         sample_o
);

  ifsa_cfg_t         cfg_q, cfg_d;
  logic              realign;
  logic              accept;
  ifsa_ctrl_t        ctrl;
  logic [WORD_W-1:0] held [0:MAX_SET_WORDS-2];
  ifsa_sample_t      sample_next;
  ifsa_sample_t      sample_q;
  logic              out_valid_q, out_valid_d;
  logic              load;

  // Configuration: decode index, realign on any valid register write
  always_comb begin
    cfg_d   = cfg_q;
    realign = 1'b0;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_GYRO_EN:  begin cfg_d.gyro_active       = cfg_data_i[0]; realign = 1'b1; end
        CFG_ACCEL_EN: begin cfg_d.accel_enable      = cfg_data_i[0]; realign = 1'b1; end
        CFG_TIME_EN:  begin cfg_d.time_steps_enable = cfg_data_i[0]; realign = 1'b1; end
        default:      begin end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Accept a word whenever the output register is free or being drained
  assign word_i.ready = !out_valid_q || sample_o.ready;
  assign accept       = word_i.valid && word_i.ready;

  ifsa_capture #(
    .MAX_SET_WORDS (MAX_SET_WORDS)
  ) u_capture (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .realign_i (realign),
    .accept_i  (accept),
    .word_i    (word_i.fifo_word),
    .ctrl_o    (ctrl),
    .held_o    (held)
  );

  ifsa_format #(
    .MAX_SET_WORDS (MAX_SET_WORDS)
  ) u_format (
    .cfg_i     (cfg_q),
    .set_len_i (ctrl.set_len),
    .word_i    (word_i.fifo_word),
    .held_i    (held),
    .sample_o  (sample_next)
  );

  // Output register: load on the closing word, drop once taken
  assign load = accept && ctrl.emit;

  always_comb begin
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
    end else if (sample_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      sample_q <= sample_next;
    end
  end

  assign sample_o.valid      = out_valid_q;
  assign sample_o.gyro_x     = sample_q.gyro_x;
  assign sample_o.gyro_y     = sample_q.gyro_y;
  assign sample_o.gyro_z     = sample_q.gyro_z;
  assign sample_o.accel_x    = sample_q.accel_x;
  assign sample_o.accel_y    = sample_q.accel_y;
  assign sample_o.accel_z    = sample_q.accel_z;
  assign sample_o.time_stamp = sample_q.time_stamp;
  assign sample_o.step_total = sample_q.step_total;

  // Position always stays inside the current set
  a_pos_in_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl.set_len != '0) |-> (ctrl.pos < ctrl.set_len))
    else $error("set position beyond set length");

  // A closing word shows up as a valid sample in the next cycle
  a_emit_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |=> out_valid_q)
    else $error("closing word did not produce a sample");

  // With nothing enabled every accepted word yields an all-zero sample
  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && cfg_q == '0 && !cfg_we_i) |=> (out_valid_q && sample_q == '0))
    else $error("empty configuration gave a non-zero sample");

  // A held sample is never overwritten before it is taken
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !sample_o.ready) |-> !load)
    else $error("pending sample overwritten");

endmodule

>>> tb/imu_fifo_sample_assembler_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imu_fifo_sample_assembler_tb: self-checking bench for the sample assembler
// Feeds FIFO words under a range of group enables and handshake pressure.
// Predicts each assembled sample independently and compares it field by field
// with what the block hands out.
// ----------------------------------------------------------------------------
module imu_fifo_sample_assembler_tb import ifsa_pkg::*; ();

  localparam int SET_CAP = 9;

  class imu_sample_predictor;
    ifsa_cfg_t         enables;
    logic [POS_W-1:0]  word_pos;
    logic [WORD_W-1:0] held [SET_CAP-1];
    ifsa_sample_t      due_samples [$];
    int unsigned       error_count;

    function new();
      enables     = '0;
      word_pos    = '0;
      error_count = 0;
      foreach (held[i]) held[i] = '0;
    endfunction

    function int unsigned words_per_set();
      int unsigned n;
      n = 0;
      if (enables.gyro_active)       n += GROUP_WORDS;
      if (enables.accel_enable)      n += GROUP_WORDS;
      if (enables.time_steps_enable) n += GROUP_WORDS;
      if (n > SET_CAP) n = SET_CAP;
      return n;
    endfunction

    // Any valid register write realigns to the start of a set
    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_GYRO_EN:  enables.gyro_active       = data[0];
        CFG_ACCEL_EN: enables.accel_enable      = data[0];
        CFG_TIME_EN:  enables.time_steps_enable = data[0];
        default: return;
      endcase
      word_pos = '0;
    endfunction

    function void take_word(logic [WORD_W-1:0] w);
      int unsigned       len;
      int unsigned       base;
      int unsigned       i;
      logic [WORD_W-1:0] set_words [FULL_SET];
      ifsa_sample_t      s;
      len = words_per_set();
      s   = '0;
      if (len == 0) begin
        word_pos = '0;
        due_samples.push_back(s);
        return;
      end
      if (word_pos + 1 < len) begin
        if (word_pos < SET_CAP - 1) held[word_pos] = w;
        word_pos = word_pos + 1'b1;
        return;
      end
      foreach (set_words[k]) set_words[k] = '0;
      for (i = 0; i + 1 < len && i < SET_CAP - 1 && i < FULL_SET; i++)
        set_words[i] = held[i];
      if (len - 1 < FULL_SET) set_words[len-1] = w;
      word_pos = '0;
      base = 0;
      if (enables.gyro_active) begin
        s.gyro_x = set_words[0];
        s.gyro_y = set_words[1];
        s.gyro_z = set_words[2];
        base += GROUP_WORDS;
      end
      if (enables.accel_enable) begin
        s.accel_x = set_words[base];
        s.accel_y = set_words[base+1];
        s.accel_z = set_words[base+2];
        base += GROUP_WORDS;
      end
      if (enables.time_steps_enable) begin
        // Low byte of the second time word is dropped
        s.time_stamp = {set_words[base][15:8], set_words[base][7:0],
                        set_words[base+1][15:8]};
        s.step_total = set_words[base+2];
      end
      due_samples.push_back(s);
    endfunction

    function void cmp_field(string name, logic [TS_W-1:0] exp, logic [TS_W-1:0] act);
      if (exp !== act) begin
        $error("%s: expected 0x%0h, got 0x%0h", name, exp, act);
        error_count++;
      end
    endfunction

    function void check_sample(ifsa_sample_t got);
      ifsa_sample_t exp;
      if (due_samples.size() == 0) begin
        $error("sample: none expected, got 0x%0h", got);
        error_count++;
        return;
      end
      exp = due_samples.pop_front();
      cmp_field("gyro_x",     exp.gyro_x,     got.gyro_x);
      cmp_field("gyro_y",     exp.gyro_y,     got.gyro_y);
      cmp_field("gyro_z",     exp.gyro_z,     got.gyro_z);
      cmp_field("accel_x",    exp.accel_x,    got.accel_x);
      cmp_field("accel_y",    exp.accel_y,    got.accel_y);
      cmp_field("accel_z",    exp.accel_z,    got.accel_z);
      cmp_field("time_stamp", exp.time_stamp, got.time_stamp);
      cmp_field("step_total", exp.step_total, got.step_total);
    endfunction
  endclass

  // Index past the last register: the block must ignore writes to it
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  // Handshake pressure per phase, in percent: none, sender idle,
  // receiver stalling, both together
  localparam int IDLE_PLAN  [4] = '{0, 50, 0, 19};
  localparam int STALL_PLAN [4] = '{0, 0, 50, 19};

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;
  int                    idle_pct;
  int                    stall_pct;
  ifsa_sample_t          seen_sample;

  imu_sample_predictor pred;

  ifsa_word_if   word_if();
  ifsa_sample_if sample_if();

  imu_fifo_sample_assembler #(
    .MAX_SET_WORDS (SET_CAP)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .word_i     (word_if),
    .sample_o   (sample_if)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  assign seen_sample = {sample_if.gyro_x, sample_if.gyro_y, sample_if.gyro_z,
                        sample_if.accel_x, sample_if.accel_y, sample_if.accel_z,
                        sample_if.time_stamp, sample_if.step_total};

  // Sample everything at the rising edge. Check the sample before noting the
  // word: a sample leaving now belongs to a set closed in an earlier cycle.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_we) pred.write_reg(cfg_idx, cfg_data);
      if (sample_if.valid && sample_if.ready) pred.check_sample(seen_sample);
      if (word_if.valid && word_if.ready) pred.take_word(word_if.fifo_word);
    end
  end

  // Receiver: redraw ready at every falling edge according to the phase
  initial begin
    sample_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      sample_if.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Offer one word; idle first at random, then hold it until taken.
  // Enter and leave at a falling edge with nothing assigned there yet.
  task automatic send_word(input logic [WORD_W-1:0] w);
    while ($urandom_range(99) < idle_pct) begin
      word_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    word_if.valid     <= 1'b1;
    word_if.fifo_word <= w;
    do @(posedge clk_i); while (!word_if.ready);
    @(negedge clk_i);
  endtask

  // Drop valid, wait for every due sample, then let the output register settle
  // so that a partial set is truly at rest
  task automatic settle();
    word_if.valid <= 1'b0;
    while (pred.due_samples.size() != 0) @(negedge clk_i);
    repeat (3) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(negedge clk_i);
    cfg_we <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic configure(input logic g, input logic a, input logic t);
    settle();
    write_reg(CFG_GYRO_EN, g);
    write_reg(CFG_ACCEL_EN, a);
    write_reg(CFG_TIME_EN, t);
    if ($urandom_range(1) == 1) write_reg(CFG_UNUSED, 1'($urandom));
  endtask

  function automatic logic [WORD_W-1:0] pick_word();
    case ($urandom_range(7))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    int n;
    pred              = new();
    rst_ni            = 1'b0;
    cfg_we            = 1'b0;
    cfg_idx           = '0;
    cfg_data          = '0;
    word_if.valid     = 1'b0;
    word_if.fifo_word = '0;
    idle_pct          = 0;
    stall_pct         = 0;
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Nothing enabled after reset: every word gives an all-zero sample
    send_word(16'h0000);
    send_word(16'hFFFF);
    send_word(16'h8001);

    // Gyro only, extremes in x and y
    configure(1'b1, 1'b0, 1'b0);
    send_word(16'hFFFF);
    send_word(16'h0000);
    send_word(16'hA5A5);

    // Abandon a partial set: rewriting a register with its own value realigns
    send_word(16'hDEAD);
    send_word(16'hDEAD);
    settle();
    write_reg(CFG_ACCEL_EN, 1'b0);
    send_word(16'h0F0F);
    send_word(16'hF0F0);
    send_word(16'h1111);

    // Every group enabled: full set, timestamp bytes easy to tell apart
    configure(1'b1, 1'b1, 1'b1);
    send_word(16'h0001);
    send_word(16'h8000);
    send_word(16'hFFFF);
    send_word(16'h7FFF);
    send_word(16'h0000);
    send_word(16'h5A5A);
    send_word(16'h12AB);
    send_word(16'hCDEF);
    send_word(16'hFFFF);

    // Time and steps only; a write to the unused index mid-set must not
    // disturb the position
    configure(1'b0, 1'b0, 1'b1);
    send_word(16'hFF00);
    settle();
    write_reg(CFG_UNUSED, 1'b1);
    send_word(16'h00FF);
    send_word(16'h1234);

    // Random words under every enable pattern in every pressure phase.
    // Segment lengths can leave partial sets behind, which the next write drops.
    for (int ph = 0; ph < 4; ph++) begin
      settle();
      idle_pct  = IDLE_PLAN[ph];
      stall_pct = STALL_PLAN[ph];
      for (int k = 0; k < 8; k++) begin
        configure(k[2], k[1], k[0]);
        n = $urandom_range(24, 40);
        repeat (n) begin
          if ($urandom_range(39) == 0) begin
            settle();
            write_reg(CFG_UNUSED, 1'($urandom));
          end
          send_word(pick_word());
        end
      end
    end

    settle();
    if (pred.error_count == 0 && pred.due_samples.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Hard stop: 2 ms is far beyond the slowest correct run
  initial begin
    #2_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

>>> imu_fifo_sample_assembler.f
rtl/ifsa_pkg.sv
rtl/ifsa_if.sv
rtl/ifsa_capture.sv
rtl/ifsa_format.sv
rtl/imu_fifo_sample_assembler.sv
tb/imu_fifo_sample_assembler_tb.sv
